// ----- rtl/pdc_pkg.sv -----
// Package for the pair difference counter: sizes, counters and controller codes.
package pdc_pkg;
  localparam int unsigned MaxItems  = 1024;
  localparam int unsigned AddrW     = $clog2(MaxItems);
  localparam int unsigned CountW    = $clog2(MaxItems + 1);
  localparam int unsigned ValueW    = 32;
  localparam int unsigned PairW     = 21;
  localparam logic [PairW-1:0] PairMax = {PairW{1'b1}};

  localparam int unsigned StateW = 3;
  localparam logic [StateW-1:0] StIdle  = 3'd0;
  localparam logic [StateW-1:0] StRdI   = 3'd1;
  localparam logic [StateW-1:0] StRdJ   = 3'd2;
  localparam logic [StateW-1:0] StCmp   = 3'd3;
  localparam logic [StateW-1:0] StDone  = 3'd4;

  typedef struct packed {
    logic load;       // store the request value (or flag a drop)
    logic clear;      // empty the set after the result
    logic set_i;      // capture value_i from RAM data
    logic rd_i;       // drive RAM address with i
    logic cmp;        // compare RAM data with target, step j
    logic step_i;     // advance i, reset j
    logic emit;       // present result
  } pdc_cmd_t;

  typedef struct packed {
    logic empty;      // no items stored
    logic j_last;     // j is at the final item
    logic i_last;     // i is at the final item
  } pdc_sts_t;
endpackage

// ----- rtl/pdc_ram.sv -----
// Generic single-port RAM with registered read.
module pdc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- rtl/pdc_datapath.sv -----
// Datapath: value store, index counters, target compare and pair accumulator.
module pdc_datapath import pdc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pdc_cmd_t                 cmd_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic signed [ValueW-1:0] diff_i,
  output pdc_sts_t                 sts_o,
  output logic [PairW-1:0]         pair_count_o,
  output logic                     overflow_o
);
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0]  i_q, j_q;
  logic              drop_q;
  logic [PairW-1:0]  sum_q;
  logic signed [ValueW:0] tgt_q;
  logic [ValueW-1:0] rdata;
  logic [AddrW-1:0]  addr;
  logic              full, we;

  assign full = (cnt_q == CountW'(MaxItems));
  assign we   = cmd_i.load && !full;
  // While comparing, the read for the next j is issued so that its data
  // arrives together with the incremented j counter.
  assign addr = cmd_i.load ? cnt_q[AddrW-1:0] :
                (cmd_i.rd_i ? i_q : (cmd_i.cmp ? j_q + AddrW'(1) : j_q));

  pdc_ram #(.Width(ValueW), .Depth(MaxItems)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(value_i), .rdata_o(rdata)
  );

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear) begin
      cnt_d = '0;
    end else if (we) begin
      cnt_d = cnt_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; drop_q <= 1'b0; sum_q <= '0; i_q <= '0; j_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.clear) begin
        drop_q <= 1'b0; sum_q <= '0; i_q <= '0; j_q <= '0;
      end else begin
        if (cmd_i.load && full) drop_q <= 1'b1;
        if (cmd_i.cmp) begin
          if ($signed({rdata[ValueW-1], rdata}) == tgt_q && sum_q != PairMax) begin
            sum_q <= sum_q + PairW'(1);
          end
        end
        if (cmd_i.step_i) begin
          i_q <= i_q + AddrW'(1);
          j_q <= '0;
        end else if (cmd_i.cmp) begin
          j_q <= j_q + AddrW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_i) begin
      tgt_q <= $signed({rdata[ValueW-1], rdata}) + $signed({diff_i[ValueW-1], diff_i});
    end
  end

  assign sts_o.empty  = (cnt_q == '0);
  assign sts_o.j_last = ({1'b0, j_q} == cnt_q - CountW'(1));
  assign sts_o.i_last = ({1'b0, i_q} == cnt_q - CountW'(1));
  assign pair_count_o = sum_q;
  assign overflow_o   = drop_q;
endmodule

// ----- rtl/pdc_ctrl.sv -----
// Controller state machine sequencing load, pair search and result.
module pdc_ctrl import pdc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     last_i,
  input  pdc_sts_t sts_i,
  output pdc_cmd_t cmd_o,
  output logic     busy
);
  logic [StateW-1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (last_i) state_d = StRdI;
        end
      end
      StRdI: begin
        if (sts_i.empty) begin
          state_d = StDone;
        end else begin
          cmd_o.rd_i = 1'b1;
          state_d = StRdJ;
        end
      end
      StRdJ: begin
        cmd_o.set_i = 1'b1;
        state_d = StCmp;
      end
      StCmp: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.j_last) begin
          if (sts_i.i_last) begin
            state_d = StDone;
          end else begin
            cmd_o.step_i = 1'b1;
            state_d = StRdI;
          end
        end
      end
      StDone: begin
        cmd_o.emit  = 1'b1;
        cmd_o.clear = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  assign busy = (state_q != StIdle);

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> cmd_o.clear) else $error("emit without clear");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone |=> state_q == StIdle) else $error("done not followed by idle");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !busy) else $error("load while busy");
endmodule

// ----- rtl/pair_difference_counter.sv -----
// Top level of the pair difference counter.
// Usage: a request is taken when start is high and busy is low; it carries
// value_i and last_i. Values go one per cycle into a 1024-entry store; values
// arriving with the store full are dropped and raise overflow_o for the set.
// The request with last_i high closes the set and busy rises. The controller
// then walks every stored element i, forms value_i + difference at 33 bits,
// and scans all elements j against it, one comparison a cycle from the single
// RAM port. For each i the controller runs StRdI, StRdJ, then StCmp per j;
// StDone gives the result. An empty set goes from StRdI to StDone.
// The result appears on pair_count_o and overflow_o for exactly one cycle
// with valid_o high; the receiver cannot stall it. The store is then empty
// and busy falls. Loading runs at one request a cycle while busy is low.
// The difference register is written through cfg_valid_i/cfg_ready_o; ready
// is always high, and writes belong to idle periods.
// Reset clears the set, the difference register and the controller; no
// clearing pass of the store is needed since only written entries are read.
module pair_difference_counter import pdc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [ValueW-1:0] value_i,
  input  logic                     last_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic signed [ValueW-1:0] cfg_data_i,
  output logic                     valid_o,
  output logic [PairW-1:0]         pair_count_o,
  output logic                     overflow_o
);
  pdc_cmd_t cmd;
  pdc_sts_t sts;
  logic signed [ValueW-1:0] diff_q;

  // The difference register accepts a write every cycle.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) diff_q <= '0;
    else if (cfg_valid_i) diff_q <= cfg_data_i;
  end

  pdc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .last_i, .sts_i(sts), .cmd_o(cmd), .busy
  );

  pdc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .value_i, .diff_i(diff_q), .sts_o(sts),
    .pair_count_o, .overflow_o
  );

  // The result strobe coincides with the controller's done state.
  assign valid_o = cmd.emit;
endmodule
